/* sv/rtip_pkg.sv */
// Shared types and constants of the radix text-to-integer parser.
package rtip_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int POSITION_WIDTH = 16;
  localparam int CHAR_WIDTH     = 16;
  localparam int RADIX_WIDTH    = 6;
  localparam int STATUS_WIDTH   = 2;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_BASE  = 2'd2;

  localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_WIDTH-1:0] RADIX_ONE   = 6'd1;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_WIDTH-1:0] BASE_MIN    = 6'd2;
  localparam logic [RADIX_WIDTH-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_WIDTH-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_WIDTH-1:0] ALPHA_BASE  = 6'd10;

  localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 16'h0020;
  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 16'h002B;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 16'h002D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 16'h0030;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 16'h0039;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_A  = 16'h0041;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_X  = 16'h0058;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_Z  = 16'h005A;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_A  = 16'h0061;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_X  = 16'h0078;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_Z  = 16'h007A;

  typedef struct packed {
    logic                  start_req;
    logic [CHAR_WIDTH-1:0] char_code;
  } char_beat_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]    value;
    logic        [STATUS_WIDTH-1:0]   status;
    logic        [POSITION_WIDTH-1:0] stop_position;
  } result_beat_t;

endpackage

/* sv/radix_text_to_integer_parser_top.sv */
// Radix text-to-integer parser: one character per beat, one result per string.
//
// Usage:
//   char channel (char_valid, char_stall, char_beat): one character per beat;
//   start_req marks the first character of a string. A string yields one
//   result beat on the res channel at the first character that is not a digit
//   of the base; later characters are dropped until the next start.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes the radix (0 = auto,
//   2..36); cfg_ready is always high. The radix is latched at each start.
// Output: results are registered in res_beat, or in skid while res_beat waits.
// Throughput: one character per cycle unless stalled; the digit multiply-add
//   and overflow compare sit between the parser state and result registers.
// Stall: the result register is backed by a one-beat skid register, so a
//   character is taken while a result waits; char_stall rises only once the
//   skid register holds a second result.
// Reset: rst (synchronous) sets radix 10, the parser idle and both output
//   registers empty; characters before the first start produce nothing.
module radix_text_to_integer_parser_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   char_valid,
  output logic                                   char_stall,
  input  rtip_pkg::char_beat_t                   char_beat,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output rtip_pkg::result_beat_t                 res_beat,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rtip_pkg::RADIX_WIDTH-1:0]       cfg_data
);

  localparam int VW     = rtip_pkg::VALUE_WIDTH;
  localparam int PW     = rtip_pkg::POSITION_WIDTH;
  localparam int RW     = rtip_pkg::RADIX_WIDTH;
  localparam int CW     = rtip_pkg::CHAR_WIDTH;
  localparam int PROD_W = VW + RW + 1;

  localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(1) << (VW - 1);
  localparam logic [PROD_W-1:0] LIMIT_POS = LIMIT_NEG - PROD_W'(1);
  localparam logic [PW-1:0]     POS_MAX   = {PW{1'b1}};

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEAD    = 3'd1;
  localparam logic [2:0] PH_SIGNED  = 3'd2;
  localparam logic [2:0] PH_ZERO    = 3'd3;
  localparam logic [2:0] PH_HEXPREF = 3'd4;
  localparam logic [2:0] PH_DIGITS  = 3'd5;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_SOME = 2'd1;
  localparam logic [1:0] SEEN_OVER = 2'd2;

  logic [RW-1:0] radix;
  logic [2:0]    phase, phase_next;
  logic          negative, negative_next;
  logic [1:0]    digit_seen, digit_seen_next;
  logic [VW-1:0] accumulator, accumulator_next;
  logic [RW-1:0] effective_base, effective_base_next;
  logic [PW-1:0] char_position, char_position_next;

  logic                   char_take;
  logic                   res_take;
  logic                   produce;
  logic                   do_digit;
  logic                   emit_now;
  logic [PW-1:0]          emit_at;
  logic [RW:0]            digit;
  logic [RW:0]            hex_digit;
  logic [RW-1:0]          base_eff;
  logic [PROD_W-1:0]      product;
  logic [PROD_W-1:0]      limit;
  logic [CW-1:0]          ch;
  rtip_pkg::result_beat_t result;
  rtip_pkg::result_beat_t skid;
  logic                   skid_valid;

  // {valid, digit value}
  function automatic logic [RW:0] digit_of(input logic [CW-1:0] c);
    logic [RW:0] r;
    r = '0;
    if (c >= rtip_pkg::CHAR_ZERO && c <= rtip_pkg::CHAR_NINE) begin
      r = {1'b1, RW'(c - rtip_pkg::CHAR_ZERO)};
    end else if (c >= rtip_pkg::CHAR_UC_A && c <= rtip_pkg::CHAR_UC_Z) begin
      r = {1'b1, RW'(c - rtip_pkg::CHAR_UC_A) + rtip_pkg::ALPHA_BASE};
    end else if (c >= rtip_pkg::CHAR_LC_A && c <= rtip_pkg::CHAR_LC_Z) begin
      r = {1'b1, RW'(c - rtip_pkg::CHAR_LC_A) + rtip_pkg::ALPHA_BASE};
    end
    return r;
  endfunction

  assign cfg_ready  = 1'b1;
  assign char_stall = skid_valid;
  assign char_take  = char_valid && !char_stall;
  assign res_take   = res_valid && !res_stall;
  assign ch         = char_beat.char_code;
  assign digit      = digit_of(ch);
  assign hex_digit  = digit_of(ch);

  always_comb begin
    phase_next          = phase;
    negative_next       = negative;
    digit_seen_next     = digit_seen;
    accumulator_next    = accumulator;
    effective_base_next = effective_base;
    char_position_next  = char_position;
    produce             = 1'b0;
    do_digit            = 1'b0;
    emit_now            = 1'b0;
    emit_at             = char_position;
    base_eff            = effective_base;
    product             = '0;
    limit               = LIMIT_POS;
    result              = '0;

    if (char_beat.start_req) begin
      negative_next      = 1'b0;
      digit_seen_next    = SEEN_NONE;
      accumulator_next   = '0;
      char_position_next = '0;
      if (radix == rtip_pkg::RADIX_ONE || radix > rtip_pkg::RADIX_MAX) begin
        produce       = 1'b1;
        result.status = rtip_pkg::STATUS_BASE;
        phase_next    = PH_IDLE;
      end else begin
        effective_base_next = radix;
        phase_next          = PH_LEAD;
      end
    end

    if (!produce) begin
      unique case (phase_next)
        PH_LEAD, PH_SIGNED: begin
          if (phase_next == PH_LEAD && ch == rtip_pkg::CHAR_SPACE) begin
            phase_next = PH_LEAD;
          end else if (phase_next == PH_LEAD && ch == rtip_pkg::CHAR_MINUS) begin
            negative_next = 1'b1;
            phase_next    = PH_SIGNED;
          end else if (phase_next == PH_LEAD && ch == rtip_pkg::CHAR_PLUS) begin
            phase_next = PH_SIGNED;
          end else if (ch == rtip_pkg::CHAR_ZERO &&
                       (effective_base_next == rtip_pkg::RADIX_AUTO ||
                        effective_base_next == rtip_pkg::BASE_HEX)) begin
            digit_seen_next = SEEN_SOME;
            phase_next      = PH_ZERO;
          end else begin
            if (effective_base_next == rtip_pkg::RADIX_AUTO) begin
              effective_base_next = rtip_pkg::BASE_DEC;
            end
            phase_next = PH_DIGITS;
            do_digit   = 1'b1;
          end
        end
        PH_ZERO: begin
          if (ch == rtip_pkg::CHAR_LC_X || ch == rtip_pkg::CHAR_UC_X) begin
            effective_base_next = rtip_pkg::BASE_HEX;
            phase_next          = PH_HEXPREF;
          end else begin
            if (effective_base_next == rtip_pkg::RADIX_AUTO) begin
              effective_base_next = rtip_pkg::BASE_OCT;
            end
            phase_next = PH_DIGITS;
            do_digit   = 1'b1;
          end
        end
        PH_HEXPREF: begin
          if (!hex_digit[RW] || hex_digit[RW-1:0] >= rtip_pkg::BASE_HEX) begin
            emit_now = 1'b1;
            emit_at  = char_position - PW'(1);
          end else begin
            phase_next = PH_DIGITS;
            do_digit   = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (do_digit) begin
        base_eff = (effective_base_next < rtip_pkg::BASE_MIN) ?
                   rtip_pkg::BASE_MIN : effective_base_next;
        limit    = negative_next ? LIMIT_NEG : LIMIT_POS;
        product  = PROD_W'(accumulator_next) * PROD_W'(base_eff) +
                   PROD_W'(digit[RW-1:0]);
        if (!digit[RW] || digit[RW-1:0] >= base_eff) begin
          emit_now = 1'b1;
          emit_at  = char_position_next;
        end else if (digit_seen_next != SEEN_OVER) begin
          if (product > limit) begin
            digit_seen_next = SEEN_OVER;
          end else begin
            accumulator_next = product[VW-1:0];
            digit_seen_next  = SEEN_SOME;
          end
        end
      end

      if (emit_now) begin
        produce = 1'b1;
        if (digit_seen_next == SEEN_OVER) begin
          result.value  = negative_next ? VW'(LIMIT_NEG) : VW'(LIMIT_POS);
          result.status = rtip_pkg::STATUS_RANGE;
        end else begin
          result.value  = negative_next ? -accumulator_next : accumulator_next;
          result.status = rtip_pkg::STATUS_OK;
        end
        result.stop_position = (digit_seen_next != SEEN_NONE) ? emit_at : '0;
        phase_next           = PH_IDLE;
      end else if (phase_next != PH_IDLE && char_position_next != POS_MAX) begin
        char_position_next = char_position_next + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix          <= rtip_pkg::RADIX_RESET;
      phase          <= PH_IDLE;
      negative       <= 1'b0;
      digit_seen     <= SEEN_NONE;
      accumulator    <= '0;
      effective_base <= rtip_pkg::RADIX_RESET;
      char_position  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      if (char_take) begin
        phase          <= phase_next;
        negative       <= negative_next;
        digit_seen     <= digit_seen_next;
        accumulator    <= accumulator_next;
        effective_base <= effective_base_next;
        char_position  <= char_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_take) begin
        res_beat   <= skid;
        skid_valid <= 1'b0;
      end
    end else if (char_take && produce) begin
      if (!res_valid || res_take) begin
        res_beat  <= result;
        res_valid <= 1'b1;
      end else begin
        skid       <= result;
        skid_valid <= 1'b1;
      end
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid register full while result register empty");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (char_take && produce) |=> (phase == PH_IDLE))
    else $error("parser not idle after emitting a result");

  a_range_saturates: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_beat.status == rtip_pkg::STATUS_RANGE) |->
    (res_beat.value == VW'(LIMIT_NEG) || res_beat.value == VW'(LIMIT_POS)))
    else $error("out-of-range result not saturated");

  a_bad_base_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_beat.status == rtip_pkg::STATUS_BASE) |->
    (res_beat.value == '0 && res_beat.stop_position == '0))
    else $error("invalid-base result carries data");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (char_stall && !$past(rst)) |=> $stable(char_position) && $stable(phase))
    else $error("parser state moved while input stalled");

endmodule

/* verif/radix_text_to_integer_parser_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the radix text-to-integer parser: strtol predictor, random strings.
module radix_text_to_integer_parser_top_test;
  import rtip_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int PHASE_ITEMS   = 135;
  localparam int LONG_DIGITS   = 60;
  localparam int RADIX_PLAN[9] = '{0, 16, 10, 1, 36, 2, 8, 63, 37};

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_SIGNED, PH_ZERO, PH_HEXPREF, PH_DIGITS
  } parse_phase_t;

  typedef enum logic [1:0] {SEEN_NONE, SEEN_SOME, SEEN_OVER} digit_seen_t;

  class conversion_scoreboard;
    logic [RADIX_WIDTH-1:0]    radix = RADIX_RESET;
    parse_phase_t              phase = PH_IDLE;
    bit                        negative;
    digit_seen_t               seen = SEEN_NONE;
    longint unsigned           acc;
    logic [RADIX_WIDTH-1:0]    base = BASE_DEC;
    logic [POSITION_WIDTH-1:0] pos = '0;
    result_beat_t              due_results[$];
    int                        fails;

    function void set_radix(logic [RADIX_WIDTH-1:0] v);
      radix = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function int digit_value(logic [CHAR_WIDTH-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return int'(c - CHAR_UC_A) + int'(ALPHA_BASE);
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return int'(c - CHAR_LC_A) + int'(ALPHA_BASE);
      return -1;
    endfunction

    function bit finish_string(logic [POSITION_WIDTH-1:0] at);
      result_beat_t r;
      if (seen == SEEN_OVER) begin
        r.value = negative ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else begin
        r.value = VALUE_WIDTH'(negative ? -acc : acc);
      end
      r.status = (seen == SEEN_OVER) ? STATUS_RANGE : STATUS_OK;
      r.stop_position = (seen != SEEN_NONE) ? at : '0;
      due_results.push_back(r);
      phase = PH_IDLE;
      return 1'b1;
    endfunction

    function bit take_digit(logic [CHAR_WIDTH-1:0] c);
      int b;
      int d;
      longint unsigned lim;
      b = (base < BASE_MIN) ? BASE_MIN : base;
      d = digit_value(c);
      if (d < 0 || d >= b) return finish_string(pos);
      if (seen == SEEN_OVER) return 1'b0;
      lim = (64'd1 << (VALUE_WIDTH - 1)) - (negative ? 64'd0 : 64'd1);
      if (acc > (lim - longint'(d)) / longint'(b)) begin
        seen = SEEN_OVER;
      end else begin
        acc = acc * b + d;
        seen = SEEN_SOME;
      end
      return 1'b0;
    endfunction

    function bit first_digit(logic [CHAR_WIDTH-1:0] c);
      if (c == CHAR_ZERO && (base == RADIX_AUTO || base == BASE_HEX)) begin
        seen = SEEN_SOME;
        phase = PH_ZERO;
        return 1'b0;
      end
      if (base == RADIX_AUTO) base = BASE_DEC;
      phase = PH_DIGITS;
      return take_digit(c);
    endfunction

    function void take_char(char_beat_t b);
      bit done;
      int d;
      logic [CHAR_WIDTH-1:0] c;
      done = 1'b0;
      c = b.char_code;
      if (b.start_req) begin
        negative = 1'b0;
        seen = SEEN_NONE;
        acc = 0;
        pos = '0;
        if (radix == RADIX_ONE || radix > RADIX_MAX) begin
          due_results.push_back('{value: '0, status: STATUS_BASE, stop_position: '0});
          phase = PH_IDLE;
          return;
        end
        base = radix;
        phase = PH_LEAD;
      end
      case (phase)
        PH_LEAD: begin
          if (c == CHAR_MINUS) begin
            negative = 1'b1;
            phase = PH_SIGNED;
          end else if (c == CHAR_PLUS) begin
            phase = PH_SIGNED;
          end else if (c != CHAR_SPACE) begin
            done = first_digit(c);
          end
        end
        PH_SIGNED: done = first_digit(c);
        PH_ZERO: begin
          if (c == CHAR_LC_X || c == CHAR_UC_X) begin
            base = BASE_HEX;
            phase = PH_HEXPREF;
          end else begin
            if (base == RADIX_AUTO) base = BASE_OCT;
            phase = PH_DIGITS;
            done = take_digit(c);
          end
        end
        PH_HEXPREF: begin
          d = digit_value(c);
          if (d < 0 || d >= int'(BASE_HEX)) begin
            done = finish_string(pos - 1'b1);
          end else begin
            phase = PH_DIGITS;
            done = take_digit(c);
          end
        end
        PH_DIGITS: done = take_digit(c);
        default: return;
      endcase
      if (!done && phase != PH_IDLE && pos != '1) pos++;
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10) begin
          $display("result with none pending: value %0d status %0d stop %0d",
                   got.value, got.status, got.stop_position);
        end
        return;
      end
      want = due_results.pop_front();
      if (got.value !== want.value || got.status !== want.status ||
          got.stop_position !== want.stop_position) begin
        fails++;
        if (fails <= 10) begin
          $display("result mismatch: expected value %0d status %0d stop %0d",
                   want.value, want.status, want.stop_position);
          $display("                 got      value %0d status %0d stop %0d",
                   got.value, got.status, got.stop_position);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   char_valid = 1'b0;
  logic                   char_stall;
  char_beat_t             char_beat = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  result_beat_t           res_beat;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [RADIX_WIDTH-1:0] cfg_data = '0;

  conversion_scoreboard board = new();
  int radix_now = 10;
  bit tx_burst;
  bit rx_quiet;
  int hold_requests = 0;
  int items = 0;
  int idle_cycles = 0;

  radix_text_to_integer_parser_top uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) board.check_result(res_beat);
      if (char_valid && !char_stall) board.take_char(char_beat);
      if (cfg_valid && cfg_ready) board.set_radix(cfg_data);
    end
    if ((res_valid && !res_stall) || (char_valid && !char_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_char(int v);
    if (v < 10) return CHAR_ZERO + CHAR_WIDTH'(v);
    return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + CHAR_WIDTH'(v - 10);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] any_char();
    case ($urandom_range(0, 5))
      0: return CHAR_WIDTH'($urandom_range(0, 65535));
      1: return digit_char($urandom_range(0, 35));
      2: return CHAR_SPACE;
      3: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      4: return $urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X;
      default: return CHAR_ZERO;
    endcase
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] stop_char(int b);
    case ($urandom_range(0, 6))
      0: return CHAR_SPACE;
      1: return ",";
      2: return '0;
      3: return '1;
      4: return CHAR_WIDTH'($urandom_range(0, 65535));
      5: return (b < 36) ? digit_char($urandom_range(b, 35)) : CHAR_MINUS;
      default: return CHAR_MINUS;
    endcase
  endfunction

  // hold the beat until taken; gap first so valid is set once per step
  task automatic send_char(bit start, logic [CHAR_WIDTH-1:0] c);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_beat <= '{start_req: start, char_code: c};
    @(posedge clk);
    while (char_stall) @(posedge clk);
    items++;
  endtask

  task automatic send_text(string s, bit with_start);
    for (int i = 0; i < s.len(); i++) send_char(with_start && i == 0, CHAR_WIDTH'(s[i]));
  endtask

  task automatic settle();
    char_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(int v);
    radix_now = v;
    cfg_valid <= 1'b1;
    cfg_data <= RADIX_WIDTH'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_number(bit cut_short);
    logic [CHAR_WIDTH-1:0] text[$];
    logic [CHAR_WIDTH-1:0] digs[$];
    longint unsigned v;
    int b;
    int n;
    int r;
    b = radix_now;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(CHAR_SPACE);
    r = $urandom_range(0, 3);
    if (r == 0) text.push_back(CHAR_PLUS);
    else if (r == 1) text.push_back(CHAR_MINUS);
    if (b == RADIX_AUTO) begin
      r = $urandom_range(0, 2);
      b = (r == 0) ? 16 : (r == 1) ? 8 : 10;
      if (r != 2) text.push_back(CHAR_ZERO);
      if (r == 0) text.push_back($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
    end else if (b == BASE_HEX && $urandom_range(0, 3) == 0) begin
      text.push_back(CHAR_ZERO);
      text.push_back($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
    end
    if (b < BASE_MIN || b > RADIX_MAX) b = 10;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      v = (64'd1 << (VALUE_WIDTH - 1)) + $urandom_range(0, 3) - 2;
      do begin
        digs.push_front(digit_char(int'(v % b)));
        v = v / b;
      end while (v != 0);
      text = {text, digs};
    end else begin
      n = (r < 4) ? $urandom_range(9, 40) : (r == 4) ? 0 : $urandom_range(1, 8);
      repeat (n) text.push_back(digit_char($urandom_range(0, b - 1)));
    end
    if (!cut_short) text.push_back(stop_char(b));
    if (text.size() == 0) text.push_back(CHAR_SPACE);
    for (int i = 0; i < text.size(); i++) send_char(i == 0, text[i]);
    if (!cut_short) repeat ($urandom_range(0, 2)) send_char(1'b0, any_char());
  endtask

  task automatic send_noise();
    bit start;
    repeat ($urandom_range(3, 8)) begin
      start = ($urandom_range(0, 3) == 0);
      send_char(start, any_char());
    end
  endtask

  initial begin
    int served;
    served = 0;
    forever begin
      if (served < hold_requests) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        served++;
      end else if (rx_quiet || $urandom_range(0, 2) != 0) begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_stall <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk);
      end
    end
  end

  initial begin
    int p;
    int r;
    int phase_end;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("7", 1'b0);
    send_text("-9x", 1'b1);
    send_text("+ ", 1'b1);
    send_text("12", 1'b1);
    send_text("9,", 1'b1);
    settle();
    write_radix(16);
    send_text("0x,", 1'b1);
    send_text("0XfF g", 1'b1);
    settle();
    write_radix(0);
    send_text("017 ", 1'b1);
    settle();
    write_radix(1);
    send_text("5", 1'b1);
    settle();
    write_radix(63);
    send_text("5", 1'b1);
    settle();
    write_radix(36);
    send_text("zZ:", 1'b1);
    settle();
    write_radix(2);
    send_text("102", 1'b1);
    send_char(1'b1, '1);
    send_char(1'b0, '0);
    send_text("-11", 1'b1);
    settle();
    write_radix(10);
    send_text("19 ", 1'b0);
    settle();

    tx_burst = 1'b1;
    send_char(1'b1, CHAR_MINUS);
    repeat (LONG_DIGITS) send_char(1'b0, digit_char($urandom_range(0, 9)));
    send_char(1'b0, CHAR_SPACE);
    tx_burst = 1'b0;

    p = 0;
    while (items < RANDOM_ITEMS) begin
      settle();
      if (p < 9) write_radix(RADIX_PLAN[p]);
      else if ($urandom_range(0, 4) == 0) write_radix($urandom_range(0, 63));
      else write_radix($urandom_range(0, 8) == 0 ? 0 : $urandom_range(2, 36));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (p == 2 || p == 6) begin
        tx_burst = 1'b1;
        rx_quiet = 1'b0;
        hold_requests <= hold_requests + 1;
      end
      phase_end = items + PHASE_ITEMS;
      while (items < phase_end) begin
        r = $urandom_range(0, 9);
        if (r == 0) send_noise();
        else send_number(r == 1);
      end
      p++;
    end

    rx_quiet = 1'b1;
    settle();
    if (board.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
